// File: rtl/mos_pkg.sv
package mos_pkg;
    localparam int CAPACITY_DEF = 64;
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic start_ins;
        logic start_rem;
        logic start_rep;
    } cmd_t;

    typedef struct packed {
        logic done;
    } sts_t;
endpackage

// File: rtl/multiset_order_statistics.sv
// Sorted multiset of signed 32-bit words, up to CAPACITY entries in one RAM.
// One item at a time: an insert that finds room, or a remove, walks the held
// entries at one cycle each through the RAM's single read port, then four
// reads fetch min, max and medians, and a restoring divider spends one
// cycle per quotient bit (47 at the default size) for the mean. An item that
// leaves the store empty skips the reads and the divider.
module multiset_order_statistics #(
    parameter int CAPACITY = mos_pkg::CAPACITY_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_kind,
    input  logic signed [31:0]            s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_status,
    output logic [$clog2(CAPACITY+1)-1:0] m_count,
    output logic signed [31:0]            m_total,
    output logic signed [31:0]            m_smallest,
    output logic signed [31:0]            m_largest,
    output logic signed [31:0]            m_median_low,
    output logic signed [31:0]            m_median_high,
    output logic                          m_median_is_pair,
    output logic signed [39:0]            m_mean
);
    mos_pkg::cmd_t cmd;
    mos_pkg::sts_t sts;

    mos_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .s_kind(s_kind), .cmd(cmd), .sts(sts)
    );

    mos_dp #(.CAPACITY(CAPACITY)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .s_value(s_value), .cmd(cmd), .sts(sts),
        .m_status(m_status), .m_count(m_count), .m_total(m_total),
        .m_smallest(m_smallest), .m_largest(m_largest),
        .m_median_low(m_median_low), .m_median_high(m_median_high),
        .m_median_is_pair(m_median_is_pair), .m_mean(m_mean)
    );
endmodule

// File: rtl/mos_ram.sv
module mos_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/mos_ctrl.sv
module mos_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    input  logic [1:0]     s_kind,
    output mos_pkg::cmd_t  cmd,
    input  mos_pkg::sts_t  sts
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WORK = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       acc;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);
    assign acc     = s_valid && s_ready;

    always_comb begin
        cmd.start_ins = acc && (s_kind == mos_pkg::KIND_INSERT);
        cmd.start_rem = acc && (s_kind == mos_pkg::KIND_REMOVE);
        cmd.start_rep = acc && (s_kind != mos_pkg::KIND_INSERT)
                        && (s_kind != mos_pkg::KIND_REMOVE);
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (acc) state_next = S_WORK;
            S_WORK: if (sts.done) state_next = S_OUT;
            S_OUT:  if (m_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule

// File: rtl/mos_dp.sv
module mos_dp #(
    parameter int CAPACITY = mos_pkg::CAPACITY_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic signed [31:0]             s_value,
    input  mos_pkg::cmd_t                  cmd,
    output mos_pkg::sts_t                  sts,
    output logic [1:0]                     m_status,
    output logic [$clog2(CAPACITY+1)-1:0]  m_count,
    output logic signed [31:0]             m_total,
    output logic signed [31:0]             m_smallest,
    output logic signed [31:0]             m_largest,
    output logic signed [31:0]             m_median_low,
    output logic signed [31:0]             m_median_high,
    output logic                           m_median_is_pair,
    output logic signed [39:0]             m_mean
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY+1);
    localparam int SW = 32 + CW;
    localparam int NW = SW + 8;

    localparam logic [3:0] P_INS_SCAN = 4'd1;
    localparam logic [3:0] P_INS_SHIFT = 4'd2;
    localparam logic [3:0] P_REM = 4'd3;
    localparam logic [3:0] P_R_MIN = 4'd4;
    localparam logic [3:0] P_R_MAX = 4'd5;
    localparam logic [3:0] P_R_ML = 4'd6;
    localparam logic [3:0] P_R_MH = 4'd7;
    localparam logic [3:0] P_DIV = 4'd8;
    localparam logic [3:0] P_DONE = 4'd9;
    localparam logic [3:0] P_IDLE = 4'd0;

    logic [3:0] ph_reg, ph_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic signed [SW-1:0] sum_reg, sum_next;
    logic signed [31:0] v_reg, v_next;
    logic [1:0] st_reg, st_next;
    logic [CW-1:0] rd_reg, rd_next, wr_reg, wr_next;
    logic pend_reg, pend_next;
    logic signed [31:0] hold_reg, hold_next;
    logic signed [31:0] mn_reg, mn_next, mx_reg, mx_next, ml_reg, ml_next, mh_reg, mh_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic [$clog2(NW+1)-1:0] bit_reg, bit_next;
    logic neg_reg, neg_next;

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic signed [31:0] wdata, rdata;

    mos_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    logic [CW-1:0] half;
    logic [CW:0] trial;
    logic [NW-1:0] absn;
    assign half = cnt_reg >> 1;
    assign trial = {rem_reg, quo_reg[NW-1]};
    assign absn = sum_reg[SW-1] ? NW'(-({{8{sum_reg[SW-1]}}, sum_reg} <<< 8))
                                : NW'({sum_reg, 8'd0});

    always_comb begin
        ph_next = ph_reg; cnt_next = cnt_reg; sum_next = sum_reg; v_next = v_reg;
        st_next = st_reg; rd_next = rd_reg; wr_next = wr_reg; pend_next = 1'b0;
        hold_next = hold_reg; mn_next = mn_reg; mx_next = mx_reg;
        ml_next = ml_reg; mh_next = mh_reg; quo_next = quo_reg; rem_next = rem_reg;
        bit_next = bit_reg; neg_next = neg_reg;
        we = 1'b0; waddr = AW'(wr_reg); wdata = hold_reg; raddr = AW'(rd_reg);
        sts.done = (ph_reg == P_DONE);
        unique case (ph_reg)
            P_IDLE: begin
                rd_next = '0; wr_next = '0;
                if (cmd.start_ins || cmd.start_rem || cmd.start_rep) begin
                    v_next = s_value; st_next = mos_pkg::ST_OK;
                end
                if (cmd.start_ins) begin
                    if (cnt_reg == CW'(CAPACITY)) begin
                        st_next = mos_pkg::ST_FULL; ph_next = P_R_MIN;
                    end else begin
                        ph_next = P_INS_SCAN; pend_next = 1'b1;
                    end
                end else if (cmd.start_rem) begin
                    ph_next = P_REM; pend_next = 1'b1;
                end else if (cmd.start_rep) begin
                    ph_next = P_R_MIN;
                end
            end
            P_INS_SCAN: begin
                // rdata holds entry rd_reg when pend_reg
                if (rd_reg == cnt_reg) begin
                    we = 1'b1; waddr = AW'(rd_reg); wdata = v_reg;
                    cnt_next = cnt_reg + 1'b1; sum_next = sum_reg + SW'(v_reg);
                    ph_next = P_R_MIN;
                end else if (!pend_reg) begin
                    pend_next = 1'b1;
                end else if (rdata > v_reg) begin
                    we = 1'b1; waddr = AW'(rd_reg); wdata = v_reg;
                    hold_next = rdata; rd_next = rd_reg + 1'b1;
                    ph_next = P_INS_SHIFT; raddr = AW'(rd_reg + 1'b1);
                    pend_next = 1'b1;
                end else begin
                    rd_next = rd_reg + 1'b1; raddr = AW'(rd_reg + 1'b1);
                    pend_next = 1'b1;
                end
            end
            P_INS_SHIFT: begin
                we = 1'b1; waddr = AW'(rd_reg); wdata = hold_reg;
                hold_next = rdata; rd_next = rd_reg + 1'b1;
                raddr = AW'(rd_reg + 1'b1); pend_next = 1'b1;
                if (rd_reg == cnt_reg) begin
                    cnt_next = cnt_reg + 1'b1; sum_next = sum_reg + SW'(v_reg);
                    ph_next = P_R_MIN; pend_next = 1'b0;
                end
            end
            P_REM: begin
                if (rd_reg == cnt_reg) begin
                    cnt_next = wr_reg; ph_next = P_R_MIN;
                end else if (!pend_reg) begin
                    pend_next = 1'b1;
                end else begin
                    if (rdata == v_reg) begin
                        sum_next = sum_reg - SW'(v_reg);
                    end else begin
                        we = 1'b1; waddr = AW'(wr_reg); wdata = rdata;
                        wr_next = wr_reg + 1'b1;
                    end
                    rd_next = rd_reg + 1'b1; raddr = AW'(rd_reg + 1'b1);
                    pend_next = 1'b1;
                end
            end
            P_R_MIN: begin
                raddr = '0;
                if (pend_reg) begin
                    mn_next = rdata; ph_next = P_R_MAX; pend_next = 1'b0;
                end else begin
                    pend_next = 1'b1;
                end
                if (cnt_reg == '0) begin
                    if (st_reg == mos_pkg::ST_OK) st_next = mos_pkg::ST_EMPTY;
                    ph_next = P_DONE; pend_next = 1'b0;
                end
            end
            P_R_MAX: begin
                raddr = AW'(cnt_reg - 1'b1);
                if (pend_reg) begin
                    mx_next = rdata; ph_next = P_R_ML; pend_next = 1'b0;
                end else begin
                    pend_next = 1'b1;
                end
            end
            P_R_ML: begin
                raddr = cnt_reg[0] ? AW'(half) : AW'(half - 1'b1);
                if (pend_reg) begin
                    ml_next = rdata; ph_next = P_R_MH; pend_next = 1'b0;
                end else begin
                    pend_next = 1'b1;
                end
            end
            P_R_MH: begin
                raddr = AW'(half);
                if (pend_reg) begin
                    mh_next = cnt_reg[0] ? 32'sd0 : rdata;
                    ph_next = P_DIV;
                    quo_next = absn; rem_next = '0; bit_next = '0;
                    neg_next = sum_reg[SW-1];
                end else begin
                    pend_next = 1'b1;
                end
            end
            P_DIV: begin
                if (trial >= {1'b0, cnt_reg}) begin
                    rem_next = CW'(trial - {1'b0, cnt_reg});
                    quo_next = {quo_reg[NW-2:0], 1'b1};
                end else begin
                    rem_next = CW'(trial);
                    quo_next = {quo_reg[NW-2:0], 1'b0};
                end
                bit_next = bit_reg + 1'b1;
                if (bit_reg == ($bits(bit_reg))'(NW-1)) ph_next = P_DONE;
            end
            P_DONE: ph_next = P_IDLE;
            default: ph_next = P_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg <= P_IDLE; cnt_reg <= '0; sum_reg <= '0; pend_reg <= 1'b0;
        end else begin
            ph_reg <= ph_next; cnt_reg <= cnt_next; sum_reg <= sum_next;
            pend_reg <= pend_next;
        end
        v_reg <= v_next; st_reg <= st_next; rd_reg <= rd_next; wr_reg <= wr_next;
        hold_reg <= hold_next; mn_reg <= mn_next; mx_reg <= mx_next;
        ml_reg <= ml_next; mh_reg <= mh_next; quo_reg <= quo_next;
        rem_reg <= rem_next; bit_reg <= bit_next; neg_reg <= neg_next;
    end

    logic empty;
    logic [NW-1:0] q_s;
    assign empty = (cnt_reg == '0);
    assign q_s = neg_reg ? -quo_reg : quo_reg;
    assign m_status = st_reg;
    assign m_count = cnt_reg;
    assign m_total = empty ? 32'sd0 : sum_reg[31:0];
    assign m_smallest = empty ? 32'sd0 : mn_reg;
    assign m_largest = empty ? 32'sd0 : mx_reg;
    assign m_median_low = empty ? 32'sd0 : ml_reg;
    assign m_median_high = empty ? 32'sd0 : mh_reg;
    assign m_median_is_pair = !empty && !cnt_reg[0];
    assign m_mean = empty ? 40'sd0 : q_s[39:0];
endmodule

// File: tb/sv/multiset_order_statistics_tb.sv
`timescale 1ns / 1ps

module multiset_order_statistics_tb;
    localparam int CAP = mos_pkg::CAPACITY_DEF;
    localparam int CW = $clog2(CAP + 1);
    localparam logic [1:0] KIND_QUERY = 2'd2;
    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]         status;
        logic [CW-1:0]      count;
        logic signed [31:0] total;
        logic signed [31:0] smallest;
        logic signed [31:0] largest;
        logic signed [31:0] median_low;
        logic signed [31:0] median_high;
        logic               median_is_pair;
        logic signed [39:0] mean;
    } stats_t;

    class stats_board;
        logic signed [31:0] held[$];
        longint             exact_total;
        stats_t             pending[$];
        int                 errors;

        function new();
            exact_total = 0;
            errors = 0;
        endfunction

        function void note_word(logic [1:0] kind, logic signed [31:0] v);
            stats_t r;
            int     pos;
            int     n;
            int     i;
            longint q;
            r = '0;
            r.status = mos_pkg::ST_OK;
            if (kind == mos_pkg::KIND_INSERT) begin
                if (held.size() >= CAP) begin
                    r.status = mos_pkg::ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < held.size() && held[pos] <= v) pos++;
                    held.insert(pos, v);
                    exact_total += longint'(v);
                end
            end else if (kind == mos_pkg::KIND_REMOVE) begin
                for (i = held.size() - 1; i >= 0; i--) begin
                    if (held[i] == v) begin
                        held.delete(i);
                        exact_total -= longint'(v);
                    end
                end
            end
            n = held.size();
            r.count = CW'(n);
            if (n == 0) begin
                if (r.status == mos_pkg::ST_OK) r.status = mos_pkg::ST_EMPTY;
            end else begin
                q = (exact_total * 256) / n;
                r.total = exact_total[31:0];
                r.smallest = held[0];
                r.largest = held[n-1];
                if (n % 2 == 0) begin
                    r.median_low = held[n/2-1];
                    r.median_high = held[n/2];
                    r.median_is_pair = 1'b1;
                end else begin
                    r.median_low = held[n/2];
                end
                r.mean = q[39:0];
            end
            pending.push_back(r);
        endfunction

        function void check_word(stats_t got);
            stats_t e;
            if (pending.size() == 0) begin
                $error("unexpected result word");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status) begin
                $error("status exp %0d got %0d", e.status, got.status); errors++;
            end
            if (got.count !== e.count) begin
                $error("count exp %0d got %0d", e.count, got.count); errors++;
            end
            if (got.total !== e.total) begin
                $error("total exp %0d got %0d", e.total, got.total); errors++;
            end
            if (got.smallest !== e.smallest) begin
                $error("smallest exp %0d got %0d", e.smallest, got.smallest); errors++;
            end
            if (got.largest !== e.largest) begin
                $error("largest exp %0d got %0d", e.largest, got.largest); errors++;
            end
            if (got.median_low !== e.median_low) begin
                $error("median_low exp %0d got %0d", e.median_low, got.median_low);
                errors++;
            end
            if (got.median_high !== e.median_high) begin
                $error("median_high exp %0d got %0d", e.median_high, got.median_high);
                errors++;
            end
            if (got.median_is_pair !== e.median_is_pair) begin
                $error("median_is_pair exp %0d got %0d", e.median_is_pair,
                       got.median_is_pair);
                errors++;
            end
            if (got.mean !== e.mean) begin
                $error("mean exp %0d got %0d", e.mean, got.mean); errors++;
            end
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_kind;
    logic signed [31:0] s_value;
    logic               m_valid;
    logic               m_ready;
    stats_t             m_word;

    multiset_order_statistics dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind), .s_value(s_value),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_status(m_word.status), .m_count(m_word.count), .m_total(m_word.total),
        .m_smallest(m_word.smallest), .m_largest(m_word.largest),
        .m_median_low(m_word.median_low), .m_median_high(m_word.median_high),
        .m_median_is_pair(m_word.median_is_pair), .m_mean(m_word.mean)
    );

    stats_board board;
    int  send_idle;
    int  recv_idle;
    int  quiet_cycles;
    bit  timed_out;
    logic signed [31:0] pool[8];

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) board.note_word(s_kind, s_value);
            if (m_valid && m_ready) board.check_word(m_word);
            if ((s_valid && s_ready) || (m_valid && m_ready) ||
                (board.pending.size() == 0 && !s_valid)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    always @(posedge aclk) begin
        if (quiet_cycles >= STALL_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("multiset_order_statistics_tb: errors");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= aresetn && ($urandom_range(99) >= recv_idle);
    end

    task automatic send_word(logic [1:0] kind, logic signed [31:0] v);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= kind;
        s_value <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge aclk);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(3))
            0: return pool[$urandom_range(7)];
            1: return $signed($urandom_range(40)) - 20;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_phase(int n);
        int k;
        int r;
        logic signed [31:0] v;
        for (k = 0; k < n; k++) begin
            r = $urandom_range(99);
            v = pick_value();
            if (board.held.size() > 0 && r >= 50 && r < 75)
                v = board.held[$urandom_range(board.held.size() - 1)];
            if (r < 50) send_word(mos_pkg::KIND_INSERT, v);
            else if (r < 80) send_word(mos_pkg::KIND_REMOVE, v);
            else if (r < 95) send_word(KIND_QUERY, v);
            else send_word(KIND_SPARE, v);
        end
    endtask

    initial begin
        int i;
        board = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_kind = KIND_QUERY;
        s_value = '0;
        m_ready = 1'b0;
        quiet_cycles = 0;
        timed_out = 1'b0;
        send_idle = 0;
        recv_idle = 0;
        pool = '{32'sh7fffffff, 32'sh80000000, 0, -1, 1, 32'sh7ffffffe,
                 32'sh80000001, 5};
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: empty ops, extremes, duplicates, wrap, full store
        send_word(KIND_QUERY, 0);
        send_word(mos_pkg::KIND_REMOVE, 7);
        send_word(mos_pkg::KIND_INSERT, 32'sh7fffffff);
        send_word(mos_pkg::KIND_INSERT, 32'sh7fffffff);
        send_word(mos_pkg::KIND_INSERT, 32'sh80000000);
        send_word(mos_pkg::KIND_INSERT, -1);
        send_word(KIND_SPARE, 32'sh55555555);
        send_word(mos_pkg::KIND_REMOVE, 12345);
        send_word(mos_pkg::KIND_REMOVE, 32'sh7fffffff);
        send_word(mos_pkg::KIND_INSERT, 32'shaaaaaaaa);
        send_word(mos_pkg::KIND_REMOVE, 32'sh80000000);
        send_word(mos_pkg::KIND_REMOVE, -1);
        send_word(mos_pkg::KIND_REMOVE, 32'shaaaaaaaa);
        for (i = 0; i < CAP; i++) send_word(mos_pkg::KIND_INSERT, 32'sh7fffffff);
        send_word(mos_pkg::KIND_INSERT, 3);
        send_word(KIND_QUERY, 0);
        send_word(mos_pkg::KIND_REMOVE, 32'sh7fffffff);
        for (i = 0; i < CAP; i++) send_word(mos_pkg::KIND_INSERT, 32'sh80000000);
        send_word(mos_pkg::KIND_INSERT, 0);
        send_word(mos_pkg::KIND_REMOVE, 32'sh80000000);
        drain();

        send_idle = 32; recv_idle = 74;
        random_phase(270);
        drain();
        send_idle = 74; recv_idle = 32;
        random_phase(270);
        send_idle = 0; recv_idle = 0;
        random_phase(264);

        drain();
        repeat (300) @(negedge aclk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("multiset_order_statistics_tb: clean");
        end else begin
            $display("multiset_order_statistics_tb: errors");
        end
        $finish;
    end
endmodule

// File: sim.f
rtl/mos_pkg.sv
rtl/mos_ram.sv
rtl/mos_ctrl.sv
rtl/mos_dp.sv
rtl/multiset_order_statistics.sv
tb/sv/multiset_order_statistics_tb.sv
